/* rtl/core/hrd_pkg.sv */
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types, constants and character helper functions of the HTTP response deframer.
// ----------------------------------------------------------------------------
package hrd_pkg;

	localparam int WinLen       = 18;
	localparam int ValueMaxLen  = 64;
	localparam int ChunkLineMax = 16;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_VALUE = 3'd1,
		M_BODY  = 3'd2,
		M_CSIZE = 3'd3,
		M_CDATA = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		K_BLANK  = 4'd0,
		K_HTTP10 = 4'd1,
		K_HTTP11 = 4'd2,
		K_SERVER = 4'd3,
		K_CTYPE  = 4'd4,
		K_TENC   = 4'd5,
		K_CONN   = 4'd6,
		K_CENC   = 4'd7,
		K_CLEN   = 4'd8,
		K_NONE   = 4'd15
	} key_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       has_byte;
		logic       transfer_end;
		logic       chunk_error;
	} result_t;

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		return v;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

endpackage

/* rtl/core/http_response_deframer_top.sv */
// ----------------------------------------------------------------------------
// http_response_deframer_top
// HTTP/1.x response body extractor on byte streams.
// ----------------------------------------------------------------------------
// One response byte per cycle in, at most one result per byte out. A byte is
// registered, then parsed against the key window and the mode register; the
// result lands in an output register. Throughput is one byte per cycle while
// the output is not stalled; a result shows on m_tvalid once its byte has
// passed the input and output registers; output stalls hold the input side.
module http_response_deframer_top import hrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] body_byte
	output logic        m_tlast,   // transfer_end
	output logic [1:0]  m_tuser    // [0] has_byte, [1] chunk_error
);
	logic       v_s1, v_s2, adv;
	logic [7:0] c_s1;
	result_t    res, res_s2;
	logic       rv;

	// stage 1 advances when its result can go to the output register
	assign adv      = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv;

	hrd_parser u_parser (
		.clk(clk), .arst_n(arst_n), .en(v_s1 && adv), .c(c_s1),
		.res(res), .res_valid(rv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (adv) v_s2 <= v_s1 && rv;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) c_s1 <= s_tdata;
		if (adv && v_s1 && rv) res_s2 <= res;
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = res_s2.body_byte;
	assign m_tlast  = res_s2.transfer_end;
	assign m_tuser  = {res_s2.chunk_error, res_s2.has_byte};
endmodule

/* rtl/core/hrd_keymatch.sv */
// ----------------------------------------------------------------------------
// hrd_keymatch
// Match window shift register and parallel key compare on the tail.
// ----------------------------------------------------------------------------
module hrd_keymatch import hrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] c,
	output key_t       key
);
	logic [7:0] win_q [WinLen];
	logic [7:0] w [WinLen];
	logic [8*WinLen-1:0] tail;

	always_comb begin
		for (int i = 0; i < WinLen - 1; i++) w[i] = win_q[i + 1];
		w[WinLen - 1] = c;
	end

	// newest byte in the lowest bits
	always_comb begin
		for (int i = 0; i < WinLen; i++) tail[8*(WinLen-1-i) +: 8] = w[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WinLen; i++) win_q[i] <= '0;
		end else if (shift) begin
			for (int i = 0; i < WinLen; i++) win_q[i] <= w[i];
		end
	end

	always_comb begin
		key = K_NONE;
		if (tail[23:0] == 24'h0a_0d_0a) key = K_BLANK;
		else if (tail[63:0] == "HTTP/1.0") key = K_HTTP10;
		else if (tail[63:0] == "HTTP/1.1") key = K_HTTP11;
		else if (tail[55:0] == "Server:") key = K_SERVER;
		else if (tail[103:0] == "Content-Type:") key = K_CTYPE;
		else if (tail[143:0] == "Transfer-Encoding:") key = K_TENC;
		else if (tail[87:0] == "Connection:") key = K_CONN;
		else if (tail[135:0] == "Content-Encoding:") key = K_CENC;
		else if (tail[119:0] == "Content-Length:") key = K_CLEN;
	end
endmodule

/* rtl/core/hrd_parser.sv */
// ----------------------------------------------------------------------------
// hrd_parser
// Mode register, value parsing and body counting for one byte per cycle when enabled.
// ----------------------------------------------------------------------------
module hrd_parser import hrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] c,
	output result_t    res,
	output logic       res_valid
);
	mode_t       mode_q, mode_d;
	key_t        mkey_q, mkey_d, key;
	logic        status_q, status_d, chunked_q, chunked_d;
	logic [31:0] blen_q, blen_d, csize_q, csize_d, cnt_q, cnt_d, acc_q, acc_d;
	logic        fnum_q, fend_q, fneg_q, fbad_q, fzero_q, fsign_q;
	logic        fnum_d, fend_d, fneg_d, fbad_d, fzero_d, fsign_d;
	logic [7:0]  held_q, held_d, hb;
	logic [31:0] cnt1;
	logic [3:0]  dv;
	logic [35:0] mul10;
	logic [7:0]  ok_ch;

	hrd_keymatch u_km (
		.clk(clk), .arst_n(arst_n), .shift(en && (mode_q == M_IDLE || mode_q > M_CDATA)),
		.c(c), .key(key)
	);

	assign cnt1 = cnt_q + 32'd1;

	always_comb begin
		case (cnt_q[2:0])
			3'd0: ok_ch = "2";
			3'd1: ok_ch = "0";
			3'd2: ok_ch = "0";
			3'd3: ok_ch = " ";
			3'd4: ok_ch = "O";
			default: ok_ch = "K";
		endcase
	end

	always_comb begin
		mode_d = mode_q; mkey_d = mkey_q; status_d = status_q; chunked_d = chunked_q;
		blen_d = blen_q; csize_d = csize_q; cnt_d = cnt_q; acc_d = acc_q;
		fnum_d = fnum_q; fend_d = fend_q; fneg_d = fneg_q; fbad_d = fbad_q;
		fzero_d = fzero_q; fsign_d = fsign_q; held_d = held_q;
		res = '0; res_valid = 1'b0;
		dv = 4'(c - 8'h30);
		mul10 = {4'd0, acc_q} * 36'd10 + 36'(dv);
		hb = held_q;
		case (mode_q)
			M_VALUE: begin
				if (cnt_q == 32'd0 && c == 8'h20) begin
				end else if (c == 8'h0d) begin
					mode_d = M_IDLE;
					if (mkey_q == K_CLEN) begin
						blen_d = fneg_q ? 32'd0 : acc_q;
						chunked_d = 1'b0;
					end else if (mkey_q == K_HTTP10 || mkey_q == K_HTTP11) begin
						blen_d = '0; csize_d = '0; chunked_d = 1'b0; status_d = 1'b1;
						if (fbad_q || cnt_q != 32'd6) begin
							res_valid = 1'b1; res.transfer_end = 1'b1;
						end
					end else if (mkey_q == K_TENC) begin
						chunked_d = 1'b1;
					end
				end else begin
					if (cnt_q >= 32'd6 || ok_ch != c) fbad_d = 1'b1;
					if (!fend_q) begin
						if (!(fnum_q || fsign_q) && is_blank(c)) begin
						end else if (!(fnum_q || fsign_q) && (c == "+" || c == "-")) begin
							fsign_d = 1'b1;
							if (c == "-") fneg_d = 1'b1;
						end else if (c >= "0" && c <= "9") begin
							acc_d = (mul10[35:32] != 4'd0) ? 32'hFFFF_FFFF : mul10[31:0];
							fnum_d = 1'b1;
						end else fend_d = 1'b1;
					end
					cnt_d = cnt1;
					if (cnt1 >= 32'(ValueMaxLen)) mode_d = M_IDLE;
				end
			end
			M_BODY: begin
				cnt_d = cnt1;
				res_valid = 1'b1; res.body_byte = c; res.has_byte = 1'b1;
				if (cnt1 >= blen_q) begin
					mode_d = M_IDLE; res.transfer_end = 1'b1;
				end
			end
			M_CSIZE: begin
				if (cnt_q == 32'd0 && (c == 8'h0d || c == 8'h0a)) begin
				end else begin
					cnt_d = cnt1;
					if (c == 8'h0a && cnt1 > 32'd2) begin
						if (!fnum_q) begin
							mode_d = M_IDLE; res_valid = 1'b1; res.chunk_error = 1'b1;
						end else begin
							csize_d = acc_q; cnt_d = '0;
							if (acc_q == 32'd0) begin
								mode_d = M_IDLE; res_valid = 1'b1; res.transfer_end = 1'b1;
							end else mode_d = M_CDATA;
						end
					end else begin
						if (cnt1 > 32'd1 && !fend_q) begin
							if (!fnum_q) begin
								if (is_blank(hb)) begin
								end else if (!is_hex(hb)) fend_d = 1'b1;
								else begin
									fnum_d = 1'b1; acc_d = {28'd0, hex_val(hb)};
									if (hb == "0") fzero_d = 1'b1;
								end
							end else if (fzero_q && (hb == "x" || hb == "X")) begin
								fzero_d = 1'b0;
							end else begin
								fzero_d = 1'b0;
								if (!is_hex(hb)) fend_d = 1'b1;
								else if (acc_q > 32'h0FFF_FFFF) acc_d = 32'hFFFF_FFFF;
								else acc_d = {acc_q[27:0], hex_val(hb)};
							end
						end
						held_d = c;
						if (cnt1 >= 32'(ChunkLineMax)) mode_d = M_IDLE;
					end
				end
			end
			M_CDATA: begin
				cnt_d = cnt1;
				res_valid = 1'b1; res.body_byte = c; res.has_byte = 1'b1;
				if (cnt1 >= csize_q) begin
					mode_d = M_CSIZE; cnt_d = '0; acc_d = '0; held_d = '0;
					{fnum_d, fend_d, fneg_d, fbad_d, fzero_d, fsign_d} = '0;
				end
			end
			default: begin
				mode_d = M_IDLE;
				if (key != K_NONE && key != K_BLANK) begin
					mkey_d = key; mode_d = M_VALUE;
					cnt_d = '0; acc_d = '0; held_d = '0;
					{fnum_d, fend_d, fneg_d, fbad_d, fzero_d, fsign_d} = '0;
				end else if (key == K_BLANK && status_q) begin
					status_d = 1'b0;
					if (chunked_q || blen_q != 32'd0) begin
						mode_d = chunked_q ? M_CSIZE : M_BODY;
						cnt_d = '0; acc_d = '0; held_d = '0;
						{fnum_d, fend_d, fneg_d, fbad_d, fzero_d, fsign_d} = '0;
					end
				end
			end
		endcase
		if (!en) res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; mkey_q <= K_BLANK; status_q <= 1'b0; chunked_q <= 1'b0;
			blen_q <= '0; csize_q <= '0; cnt_q <= '0; acc_q <= '0; held_q <= '0;
			{fnum_q, fend_q, fneg_q, fbad_q, fzero_q, fsign_q} <= '0;
		end else if (en) begin
			mode_q <= mode_d; mkey_q <= mkey_d; status_q <= status_d; chunked_q <= chunked_d;
			blen_q <= blen_d; csize_q <= csize_d; cnt_q <= cnt_d; acc_q <= acc_d;
			held_q <= held_d;
			{fnum_q, fend_q, fneg_q, fbad_q, fzero_q, fsign_q} <=
				{fnum_d, fend_d, fneg_d, fbad_d, fzero_d, fsign_d};
		end
	end
endmodule

/* rtl/core/hrd_checker.sv */
// ----------------------------------------------------------------------------
// hrd_checker
// Port-level checks on the deframer output stream.
// ----------------------------------------------------------------------------
module hrd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output dropped while stalled");
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tlast && !m_tuser[0])
		else $error("chunk error combined with other flags");
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[0] || m_tlast || m_tuser[1])
		else $error("empty result");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("data without byte flag");
endmodule

bind http_response_deframer_top hrd_checker u_hrd_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);
